@@ hw/rtl/sorted_priority_store_defines.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the sorted priority store.
// The macros expect i_clk and i_rst_n to be visible in the calling module.
// ---------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_STORE_DEFINES_SVH
`define SORTED_PRIORITY_STORE_DEFINES_SVH

// Same-cycle implication, checked only outside reset.
`define SPS_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sorted priority store: same-cycle check failed");

// Next-cycle implication, checked only outside reset.
`define SPS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sorted priority store: next-cycle check failed");

`endif

@@ hw/rtl/sps_pkg.sv @@
// ---------------------------------------------------------------------------
// sps_pkg
// Types and constants shared by the sorted priority store modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package sps_pkg;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 72;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam int PORT_VAL_W  = 32;
    localparam int COUNT_OUT_W = 5;

    // Register index, taken from paddr[2].
    localparam logic REG_EMPTY_MARKER = 1'b0;
    localparam logic [APB_DATA_W-1:0] EMPTY_MARKER_RESET = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_QUERY  = 2'd2
    } t_op;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    // Input transaction payload, lowest field in the lowest bits.
    typedef struct packed {
        logic [5:0]            pad;
        logic [PORT_VAL_W-1:0] value;
        logic [1:0]            operation;
    } t_item;

    // Result transaction payload, lowest field in the lowest bits.
    typedef struct packed {
        logic                   is_empty;
        logic [COUNT_OUT_W-1:0] entry_count_out;
        logic [PORT_VAL_W-1:0]  min_value;
        logic                   removed_valid;
        logic [PORT_VAL_W-1:0]  removed_value;
        logic                   insert_ok;
    } t_result;

    typedef struct packed {
        logic load;
        logic exec;
    } t_dp_cmd;

endpackage

@@ hw/rtl/sps_cfg.sv @@
// ---------------------------------------------------------------------------
// sps_cfg
// APB register block holding the empty marker.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sps_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_psel,
    input  logic                            i_penable,
    input  logic                            i_pwrite,
    input  logic [sps_pkg::APB_ADDR_W-1:0]  i_paddr,
    input  logic [sps_pkg::APB_DATA_W-1:0]  i_pwdata,
    output logic [sps_pkg::APB_DATA_W-1:0]  o_prdata,
    output logic                            o_pready,
    output logic [sps_pkg::APB_DATA_W-1:0]  o_empty_marker
);
    import sps_pkg::*;

    logic [APB_DATA_W-1:0] r_empty_marker;
    logic                  w_wr;

    assign w_wr = i_psel && i_penable && i_pwrite && (i_paddr[2] == REG_EMPTY_MARKER);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_empty_marker <= EMPTY_MARKER_RESET;
        end else if (w_wr) begin
            r_empty_marker <= i_pwdata;
        end
    end

    always_comb begin
        if (i_paddr[2] == REG_EMPTY_MARKER) begin
            o_prdata = r_empty_marker;
        end else begin
            o_prdata = '0;
        end
    end

    assign o_pready       = 1'b1;
    assign o_empty_marker = r_empty_marker;

endmodule

@@ hw/rtl/sps_datapath.sv @@
// ---------------------------------------------------------------------------
// sps_datapath
// Row of value cells kept in descending order, entry count, minimum
// register and result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sps_datapath #(
    parameter int CAPACITY    = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  sps_pkg::t_dp_cmd                i_cmd,
    input  sps_pkg::t_item                  i_item,
    input  logic [sps_pkg::APB_DATA_W-1:0]  i_empty_marker,
    output sps_pkg::t_result                o_result
);
    import sps_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    logic [1:0]             r_op;
    logic [VALUE_WIDTH-1:0] r_val;
    logic [VALUE_WIDTH-1:0] r_cells [CAPACITY];
    logic [CW-1:0]          r_count;
    logic [VALUE_WIDTH-1:0] r_min;
    t_result                r_result;

    logic [VALUE_WIDTH-1:0] n_ins   [CAPACITY];
    logic [VALUE_WIDTH-1:0] n_rem   [CAPACITY];
    logic [CAPACITY-1:0]    w_ge;
    logic [CW-1:0]          n_count;
    logic [VALUE_WIDTH-1:0] n_min;
    t_result                n_result;

    logic                   w_full;
    logic                   w_empty;
    logic                   w_ins_ok;
    logic                   w_rem_ok;
    logic [VALUE_WIDTH+PORT_VAL_W-1:0] w_in_ext;
    logic [VALUE_WIDTH+PORT_VAL_W-1:0] w_max_ext;
    logic [VALUE_WIDTH+PORT_VAL_W-1:0] w_min_ext;
    logic [CW+COUNT_OUT_W-1:0]         w_count_ext;

    // The store value follows the port bits: zero-extended or truncated.
    assign w_in_ext = {{VALUE_WIDTH{1'b0}}, i_item.value};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_item.operation;
            r_val <= w_in_ext[VALUE_WIDTH-1:0];
        end
    end

    assign w_full   = (r_count == CW'(CAPACITY));
    assign w_empty  = (r_count == '0);
    assign w_ins_ok = (r_op == OP_INSERT) && !w_full;
    assign w_rem_ok = (r_op == OP_REMOVE) && !w_empty;

    // Cell 0 holds the largest value. A cell at or above the count never
    // claims to be greater or equal, so the new value lands at the first
    // cell that is smaller or unused, and the cells behind it move down.
    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            assign w_ge[g] = (CW'(g) < r_count) &&
                             ($signed(r_cells[g]) >= $signed(r_val));
            if (g == 0) begin : g_head
                assign n_ins[g] = w_ge[g] ? r_cells[g] : r_val;
            end else begin : g_body
                assign n_ins[g] = w_ge[g]   ? r_cells[g] :
                                  w_ge[g-1] ? r_val      : r_cells[g-1];
            end
            if (g == CAPACITY - 1) begin : g_tail
                assign n_rem[g] = r_cells[g];
            end else begin : g_move
                assign n_rem[g] = r_cells[g+1];
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < CAPACITY; i++) begin
            if (i_cmd.exec && w_ins_ok) begin
                r_cells[i] <= n_ins[i];
            end else if (i_cmd.exec && w_rem_ok) begin
                r_cells[i] <= n_rem[i];
            end
        end
    end

    always_comb begin
        n_count = r_count;
        n_min   = r_min;
        if (w_ins_ok) begin
            n_count = r_count + CW'(1);
            if (w_empty || ($signed(r_val) < $signed(r_min))) begin
                n_min = r_val;
            end
        end else if (w_rem_ok) begin
            n_count = r_count - CW'(1);
        end
    end

    assign w_max_ext   = {{PORT_VAL_W{1'b0}}, r_cells[0]};
    assign w_min_ext   = {{PORT_VAL_W{1'b0}}, n_min};
    assign w_count_ext = {{COUNT_OUT_W{1'b0}}, n_count};

    always_comb begin
        n_result.insert_ok     = w_ins_ok;
        n_result.removed_valid = w_rem_ok;
        if (w_rem_ok) begin
            n_result.removed_value = w_max_ext[PORT_VAL_W-1:0];
        end else if (r_op == OP_REMOVE) begin
            n_result.removed_value = i_empty_marker;
        end else begin
            n_result.removed_value = '0;
        end
        n_result.is_empty        = (n_count == '0);
        n_result.entry_count_out = w_count_ext[COUNT_OUT_W-1:0];
        n_result.min_value       = (n_count == '0) ? i_empty_marker
                                                   : w_min_ext[PORT_VAL_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_min    <= n_min;
            r_result <= n_result;
        end
    end

    assign o_result = r_result;

endmodule

@@ hw/rtl/sps_ctrl.sv @@
// ---------------------------------------------------------------------------
// sps_ctrl
// Sequencer for one operation at a time and the result valid flag.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "sorted_priority_store_defines.svh"

module sps_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output sps_pkg::t_dp_cmd  o_cmd
);
    import sps_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_accept;

    // In the idle state, a new transaction is taken once the result register is free or drains now.
    assign o_in_ready = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign w_accept   = o_in_ready && i_in_valid;

    always_comb begin
        unique case (r_state)
            ST_IDLE: begin
                n_state = w_accept ? ST_EXEC : ST_IDLE;
            end
            ST_EXEC: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd.load  = 1'b0;
        o_cmd.exec  = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.load = w_accept;
            end
            ST_EXEC: begin
                o_cmd.exec  = 1'b1;
                n_out_valid = 1'b1;
            end
            default: begin
                o_cmd.load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    `SPS_ASSERT_IMPLY(a_exec_out_free, r_state == ST_EXEC, !r_out_valid)
    `SPS_ASSERT_NEXT(a_accept_to_exec, w_accept, r_state == ST_EXEC)
    `SPS_ASSERT_NEXT(a_exec_gives_result, r_state == ST_EXEC, r_out_valid && (r_state == ST_IDLE))

endmodule

@@ hw/rtl/sorted_priority_store.sv @@
// ---------------------------------------------------------------------------
// sorted_priority_store
// Double-ended priority store: insert, remove maximum and query on a
// descending row of value cells, with an APB register for the empty marker.
// ---------------------------------------------------------------------------
// Channel   Direction  Handshake                   Payload
// s_axis    in         tvalid / tready             operation, value
// m_axis    out        tvalid / tready             one result per operation
// apb       in/out     psel, penable, pready       empty_marker register
//
// Each operation is latched in the accept cycle, and the execute cycle
// updates all cells in parallel and loads the result register.
// s_axis_tready is high in the idle state once the result register is empty
// or is taken in the same cycle, so m_axis_tready low stalls the input.
// Reset empties the store (count zero) and sets the empty marker to -1.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_priority_store #(
    parameter int CAPACITY    = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // operation[1:0], value[33:2], zero fill[39:34]
    input  logic [sps_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // insert_ok[0], removed_value[32:1], removed_valid[33], min_value[65:34],
    // entry_count_out[70:66], is_empty[71]
    output logic [sps_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [sps_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [sps_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [sps_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import sps_pkg::*;

    t_item                 w_item;
    t_result               w_result;
    t_dp_cmd               w_cmd;
    logic [APB_DATA_W-1:0] w_empty_marker;

    assign w_item       = s_axis_tdata;
    assign m_axis_tdata = w_result;

    sps_cfg u_cfg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .o_prdata       (prdata),
        .o_pready       (pready),
        .o_empty_marker (w_empty_marker)
    );

    sps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (w_cmd)
    );

    sps_datapath #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_item         (w_item),
        .i_empty_marker (w_empty_marker),
        .o_result       (w_result)
    );

endmodule

@@ tb/sps_checker.sv @@
// ---------------------------------------------------------------------------
// sps_checker
// Watches the input, result and register channels of the sorted priority
// store. It keeps its own ascending copy of the stored values, works out the
// result of every accepted operation, and compares each result transaction
// field by field with the oldest outstanding prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sps_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_op_valid,
    input  logic                               i_op_ready,
    input  logic [sps_pkg::IN_TDATA_W-1:0]     i_op_data,
    input  logic                               i_res_valid,
    input  logic                               i_res_ready,
    input  logic [sps_pkg::OUT_TDATA_W-1:0]    i_res_data,
    input  logic                               i_psel,
    input  logic                               i_penable,
    input  logic                               i_pwrite,
    input  logic [sps_pkg::APB_ADDR_W-1:0]     i_paddr,
    input  logic [sps_pkg::APB_DATA_W-1:0]     i_pwdata,
    input  logic [sps_pkg::APB_DATA_W-1:0]     i_prdata,
    input  logic                               i_pready,
    output int                                 o_pending,
    output int                                 o_error_count
);

    import sps_pkg::*;

    localparam int STORE_DEPTH = 16;

    typedef logic signed [PORT_VAL_W-1:0] t_value;

    t_value  stored_vals[$];
    t_result predicted_results[$];
    t_value  empty_marker;

    initial begin
        o_pending     = 0;
        o_error_count = 0;
        empty_marker  = EMPTY_MARKER_RESET;
    end

    // Applies one operation to the shadow store and returns its result.
    function automatic t_result apply_operation(input t_item item);
        t_result res;
        int      pos;
        res = '0;
        case (item.operation)
            OP_INSERT: begin
                if (stored_vals.size() < STORE_DEPTH) begin
                    pos = 0;
                    // Equal values keep arrival order: stop at the first one not smaller.
                    while (pos < stored_vals.size() && stored_vals[pos] < t_value'(item.value))
                        pos++;
                    stored_vals.insert(pos, item.value);
                    res.insert_ok = 1'b1;
                end
            end
            OP_REMOVE: begin
                if (stored_vals.size() > 0) begin
                    res.removed_value = stored_vals.pop_back();
                    res.removed_valid = 1'b1;
                end else begin
                    res.removed_value = empty_marker;
                end
            end
            default: begin
                // Query and the unused code leave the store alone.
            end
        endcase
        res.min_value       = (stored_vals.size() > 0) ? stored_vals[0] : empty_marker;
        res.entry_count_out = COUNT_OUT_W'(stored_vals.size());
        res.is_empty        = (stored_vals.size() == 0);
        return res;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] exp_val,
                                 input logic [31:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, exp_val, act_val);
            o_error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            stored_vals.delete();
            predicted_results.delete();
            empty_marker = EMPTY_MARKER_RESET;
        end else begin
            if (i_res_valid && i_res_ready) begin
                got = i_res_data;
                if (predicted_results.size() == 0) begin
                    $error("result transaction with no operation outstanding: 0x%0h",
                           i_res_data);
                    o_error_count++;
                end else begin
                    want = predicted_results.pop_front();
                    compare_field("insert_ok", 32'(want.insert_ok), 32'(got.insert_ok));
                    compare_field("removed_value", want.removed_value, got.removed_value);
                    compare_field("removed_valid", 32'(want.removed_valid),
                                  32'(got.removed_valid));
                    compare_field("min_value", want.min_value, got.min_value);
                    compare_field("entry_count_out", 32'(want.entry_count_out),
                                  32'(got.entry_count_out));
                    compare_field("is_empty", 32'(want.is_empty), 32'(got.is_empty));
                end
            end
            if (i_op_valid && i_op_ready)
                predicted_results.push_back(apply_operation(t_item'(i_op_data)));
            if (i_psel && i_penable && i_pready && i_paddr[2] == REG_EMPTY_MARKER) begin
                if (i_pwrite)
                    empty_marker = i_pwdata;
                else
                    compare_field("prdata", empty_marker, i_prdata);
            end
        end
        o_pending = predicted_results.size();
    end

endmodule

@@ tb/tb_top.sv @@
// ---------------------------------------------------------------------------
// tb_top
// Drives the sorted priority store with a short directed sequence and then
// with random fill, drain and mixed bursts under several empty markers and
// idle patterns on both stream channels. The checker predicts and compares;
// this module makes the stimulus and prints the verdict.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    import sps_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [APB_ADDR_W-1:0] ADDR_EMPTY_MARKER = {REG_EMPTY_MARKER, 2'b00};
    localparam int ITEMS_PER_PHASE = 180;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr = '0;
    logic [APB_DATA_W-1:0]  pwdata = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    int pending;
    int error_count;
    int src_idle_pct = 0;
    int sink_stall_pct = 0;

    always #5 i_clk = ~i_clk;

    sorted_priority_store i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    sps_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op_valid    (s_axis_tvalid),
        .i_op_ready    (s_axis_tready),
        .i_op_data     (s_axis_tdata),
        .i_res_valid   (m_axis_tvalid),
        .i_res_ready   (m_axis_tready),
        .i_res_data    (m_axis_tdata),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .i_prdata      (prdata),
        .i_pready      (pready),
        .o_pending     (pending),
        .o_error_count (error_count)
    );

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_op(input logic [1:0] op, input logic [31:0] val);
        t_item item;
        item = '0;
        item.operation = op;
        item.value = val;
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= item;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic apb_access(input logic write, input logic [APB_ADDR_W-1:0] addr,
                              input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    // Mix of near-zero values for ties, extremes and full-range random words.
    function automatic logic [31:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 25)
            return 32'($signed($urandom_range(6)) - 3);
        if (r < 40) begin
            case ($urandom_range(3))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'hFFFF_FFFF;
                default: return 32'h0;
            endcase
        end
        return $urandom();
    endfunction

    task automatic run_phase(input int src_idle, input int sink_stall,
                             input logic [31:0] marker);
        int sent;
        int burst;
        int mode;
        int r;
        logic [1:0] op;
        wait_idle();
        apb_access(1'b1, ADDR_EMPTY_MARKER, marker);
        apb_access(1'b0, ADDR_EMPTY_MARKER, '0);
        src_idle_pct = src_idle;
        sink_stall_pct = sink_stall;
        sent = 0;
        while (sent < ITEMS_PER_PHASE) begin
            // Fill bursts mostly insert, drain bursts mostly remove, mixed bursts balance the two.
            mode  = $urandom_range(2);
            burst = $urandom_range(40, 8);
            repeat (burst) begin
                r = $urandom_range(99);
                case (mode)
                    0:       op = (r < 80) ? OP_INSERT : (r < 90) ? OP_REMOVE :
                                  (r < 95) ? OP_QUERY : OP_UNUSED;
                    1:       op = (r < 15) ? OP_INSERT : (r < 88) ? OP_REMOVE :
                                  (r < 95) ? OP_QUERY : OP_UNUSED;
                    default: op = (r < 45) ? OP_INSERT : (r < 85) ? OP_REMOVE :
                                  (r < 95) ? OP_QUERY : OP_UNUSED;
                endcase
                send_op(op, pick_value());
                sent++;
            end
        end
    endtask

    initial begin
        logic [31:0] fill_vals[12];
        fill_vals = '{32'd5, -32'sd5, 32'd5, 32'd100, -32'sd100, 32'h4000_0000,
                      32'hC000_0000, 32'd1, 32'd2, -32'sd2, 32'd3, 32'h7FFF_FFFE};
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset value of the marker, then the empty-store cases.
        apb_access(1'b0, ADDR_EMPTY_MARKER, '0);
        send_op(OP_QUERY, 32'h1234_5678);
        send_op(OP_REMOVE, 32'hFFFF_FFFF);
        send_op(OP_UNUSED, 32'h0);
        send_op(OP_INSERT, 32'h0);
        send_op(OP_INSERT, 32'h7FFF_FFFF);
        send_op(OP_INSERT, 32'h8000_0000);
        send_op(OP_INSERT, 32'hFFFF_FFFF);
        send_op(OP_INSERT, 32'h0);
        send_op(OP_QUERY, 32'h0);
        send_op(OP_REMOVE, 32'h0);
        foreach (fill_vals[i])
            send_op(OP_INSERT, fill_vals[i]);
        // The store now holds sixteen values, so this insert is refused.
        send_op(OP_INSERT, 32'h8000_0000);
        send_op(OP_REMOVE, 32'h0);
        send_op(OP_QUERY, 32'hFFFF_FFFF);

        run_phase(0, 0, 32'h8000_0000);
        run_phase(56, 0, 32'h7FFF_FFFF);
        run_phase(0, 56, 32'h0000_0000);
        run_phase(37, 37, $urandom());

        wait_idle();
        repeat (10) @(negedge i_clk);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
